/* rtl/core/iac_pkg.sv */
`default_nettype none

package iac_pkg;

  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CODE_W  = 32;
  localparam int unsigned CFG_N   = 8;
  localparam int unsigned CFG_IDX_W = $clog2(CFG_N);

  localparam logic [TIME_W-1:0] HOLDOFF_MS = TIME_W'(2000);

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DOOR_CODE      = 3'd0,
    CFG_MOTION_CODE    = 3'd1,
    CFG_ARM_CODE_A     = 3'd2,
    CFG_DISARM_CODE_A  = 3'd3,
    CFG_ARM_CODE_B     = 3'd4,
    CFG_DISARM_CODE_B  = 3'd5,
    CFG_START_DELAY    = 3'd6,
    CFG_REPEAT_INTV    = 3'd7
  } cfg_idx_t;

  // event codes reported in event_res
  typedef enum logic [3:0] {
    EV_NONE     = 4'd0,
    EV_ARMED    = 4'd1,
    EV_DISARMED = 4'd2,
    EV_HOLDOFF  = 4'd3,
    EV_OFF      = 4'd4,
    EV_START    = 4'd5,
    EV_REPEAT   = 4'd6,
    EV_DOOR     = 4'd7,
    EV_MOTION   = 4'd8,
    EV_UNKNOWN  = 4'd9
  } ev_t;

  typedef struct packed {
    logic [CODE_W-1:0] door_code;
    logic [CODE_W-1:0] motion_code;
    logic [CODE_W-1:0] arm_code_a;
    logic [CODE_W-1:0] disarm_code_a;
    logic [CODE_W-1:0] arm_code_b;
    logic [CODE_W-1:0] disarm_code_b;
    logic [TIME_W-1:0] start_delay_ms;
    logic [TIME_W-1:0] repeat_interval_ms;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0] now_ms;
    logic              code_valid;
    logic [CODE_W-1:0] rx_code;
  } in_item_t;

  typedef struct packed {
    logic       armed;
    logic       alarm;
    logic       door_alarm;
    logic       motion_alarm;
    logic       arming_tone;
    logic       off_tone;
    logic [3:0] event_res;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/core/iac_cfg_regs.sv */
`default_nettype none

module iac_cfg_regs
  import iac_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CODE_W-1:0]    cfg_wdata,
  output cfg_t                      cfg
);

  cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DOOR_CODE:     cfg_nxt.door_code          = cfg_wdata;
        CFG_MOTION_CODE:   cfg_nxt.motion_code        = cfg_wdata;
        CFG_ARM_CODE_A:    cfg_nxt.arm_code_a         = cfg_wdata;
        CFG_DISARM_CODE_A: cfg_nxt.disarm_code_a      = cfg_wdata;
        CFG_ARM_CODE_B:    cfg_nxt.arm_code_b         = cfg_wdata;
        CFG_DISARM_CODE_B: cfg_nxt.disarm_code_b      = cfg_wdata;
        CFG_START_DELAY:   cfg_nxt.start_delay_ms     = cfg_wdata;
        CFG_REPEAT_INTV:   cfg_nxt.repeat_interval_ms = cfg_wdata;
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

/* rtl/core/iac_decide.sv */
`default_nettype none

module iac_decide
  import iac_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire in_item_t item,
  input  wire logic     step_en,
  output out_item_t     res
);

  logic              armed_r, armed_nxt;
  logic [TIME_W-1:0] last_arm_r, last_arm_nxt;
  logic [TIME_W-1:0] last_disarm_r, last_disarm_nxt;
  logic [TIME_W-1:0] last_door_r, last_door_nxt;
  logic [TIME_W-1:0] last_motion_r, last_motion_nxt;
  logic [TIME_W-1:0] last_alarm_r, last_alarm_nxt;

  logic [TIME_W-1:0] d_arm, d_disarm, d_door, d_motion, d_alarm, d_own;
  logic is_arm, is_disarm, is_door, is_motion;
  logic tone, off_tone;
  ev_t  ev;

  // wrapped elapsed times
  assign d_arm    = item.now_ms - last_arm_r;
  assign d_disarm = item.now_ms - last_disarm_r;
  assign d_door   = item.now_ms - last_door_r;
  assign d_motion = item.now_ms - last_motion_r;
  assign d_alarm  = item.now_ms - last_alarm_r;

  assign is_arm    = (item.rx_code == cfg.arm_code_a) || (item.rx_code == cfg.arm_code_b);
  assign is_disarm = (item.rx_code == cfg.disarm_code_a) ||
                     (item.rx_code == cfg.disarm_code_b);
  assign is_door   = (item.rx_code == cfg.door_code);
  assign is_motion = (item.rx_code == cfg.motion_code);

  // door wins when both sensor codes match
  assign d_own = is_door ? d_door : d_motion;

  // tone is judged on the state before this beat
  assign tone = armed_r && (d_arm <= cfg.start_delay_ms);

  always_comb begin
    ev              = EV_NONE;
    off_tone        = 1'b0;
    armed_nxt       = armed_r;
    last_arm_nxt    = last_arm_r;
    last_disarm_nxt = last_disarm_r;
    last_door_nxt   = last_door_r;
    last_motion_nxt = last_motion_r;
    last_alarm_nxt  = last_alarm_r;
    if (item.code_valid) begin
      priority if (is_arm) begin
        if (d_arm <= HOLDOFF_MS) begin
          ev = EV_HOLDOFF;
        end else begin
          ev           = EV_ARMED;
          armed_nxt    = 1'b1;
          last_arm_nxt = item.now_ms;
        end
      end else if (is_disarm) begin
        if (d_disarm <= HOLDOFF_MS) begin
          ev = EV_HOLDOFF;
        end else begin
          ev              = EV_DISARMED;
          armed_nxt       = 1'b0;
          last_disarm_nxt = item.now_ms;
          off_tone        = 1'b1;
        end
      end else if (is_door || is_motion) begin
        priority if (d_own <= HOLDOFF_MS) begin
          ev = EV_HOLDOFF;
        end else if (!armed_r) begin
          ev = EV_OFF;
        end else if (d_arm <= cfg.start_delay_ms) begin
          ev = EV_START;
        end else if (d_alarm <= cfg.repeat_interval_ms) begin
          ev = EV_REPEAT;
        end else begin
          last_alarm_nxt = item.now_ms;
          if (is_door) begin
            ev            = EV_DOOR;
            last_door_nxt = item.now_ms;
          end else begin
            ev              = EV_MOTION;
            last_motion_nxt = item.now_ms;
          end
        end
      end else begin
        ev = EV_UNKNOWN;
      end
    end
  end

  always_comb begin
    res.armed        = armed_nxt;
    res.alarm        = (ev == EV_DOOR) || (ev == EV_MOTION);
    res.door_alarm   = (ev == EV_DOOR);
    res.motion_alarm = (ev == EV_MOTION);
    res.arming_tone  = tone;
    res.off_tone     = off_tone;
    res.event_res    = ev;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      armed_r       <= 1'b0;
      last_arm_r    <= '0;
      last_disarm_r <= '0;
      last_door_r   <= '0;
      last_motion_r <= '0;
      last_alarm_r  <= '0;
    end else if (step_en) begin
      armed_r       <= armed_nxt;
      last_arm_r    <= last_arm_nxt;
      last_disarm_r <= last_disarm_nxt;
      last_door_r   <= last_door_nxt;
      last_motion_r <= last_motion_nxt;
      last_alarm_r  <= last_alarm_nxt;
    end
  end

`ifndef SYNTHESIS
  // a raised alarm stamps the alarm time with this beat's time
  a_alarm_stamp: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && res.alarm) |=> (last_alarm_r == $past(item.now_ms)))
    else $error("alarm time not stamped");

  // an accepted arm leaves the block armed
  a_arm_sets: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && ev == EV_ARMED) |=> armed_r)
    else $error("arm did not set armed state");

  // state only moves on a step
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> ($stable(armed_r) && $stable(last_arm_r) && $stable(last_alarm_r)))
    else $error("state changed without a step");
`endif

endmodule

`default_nettype wire

/* rtl/core/intrusion_alarm_controller_core.sv */
`default_nettype none

// Channel   Ports                                Payload
// --------  -----------------------------------  -----------------------------
// input     in_valid, in_stall, in_data          in_item_t (now_ms, code, ...)
// result    out_valid, out_stall, out_data       out_item_t (armed, alarm, ...)
// config    cfg_we, cfg_index, cfg_wdata         one 32-bit register per beat
//
// One poll per cycle sustained while out_stall is low; a result passes through
// the input register, then the decision and state update into the result
// register. The state registers update in the same edge the result loads,
// so the next poll always sees this one's effect.
// Reset (rst_n low, synchronous) clears both stage valids, the armed state,
// all timestamps and all config registers.
// out_stall backs up into in_stall in the same cycle once both stages are full.

module intrusion_alarm_controller_core
  import iac_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // poll channel
  input  wire logic                 in_valid,
  output      logic                 in_stall,
  input  wire in_item_t             in_data,
  // result channel
  output      logic                 out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  // config write port
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CODE_W-1:0]    cfg_wdata
);

  cfg_t      cfg;
  out_item_t res;

  // input register
  logic     s1_valid_r, s1_valid_nxt;
  in_item_t s1_item_r;

  // result register
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r;

  logic out_ready;  // result register free this cycle
  logic in_take;    // input beat accepted
  logic step;       // stage 1 moves to the result register

  assign out_ready = !out_valid_r || !out_stall;
  assign step      = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  iac_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  iac_decide u_decide (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .item    (s1_item_r),
    .step_en (step),
    .res     (res)
  );

  always_comb begin
    priority if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (step) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_comb begin
    if (out_ready) begin
      out_valid_nxt = s1_valid_r;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_item_r <= in_data;
    end
    if (step) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // an alarm never comes out of a disarmed block
  a_alarm_armed: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.alarm) |-> out_data_r.armed)
    else $error("alarm reported while disarmed");

  // off tone only with a disarm event
  a_off_tone: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.off_tone) |->
      (!out_data_r.armed && out_data_r.event_res == EV_DISARMED))
    else $error("off tone without disarm");

  // at most one sensor credited per alarm
  a_one_sensor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_data_r.door_alarm && out_data_r.motion_alarm))
    else $error("both sensors flagged");

  // an empty input stage never stalls the input
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("stall with empty input stage");
`endif

endmodule

`default_nettype wire

/* verif/intrusion_alarm_controller_core_tb.sv */
`timescale 1ns / 100ps

module intrusion_alarm_controller_core_tb
  import iac_pkg::*;
;

  // Poll predictor plus the queue of results still owed by the block.
  class alarm_scoreboard;
    cfg_t              cfg;
    bit                armed;
    logic [TIME_W-1:0] t_arm, t_disarm, t_door, t_motion, t_alarm;
    out_item_t         pending_results[$];
    int                failures;

    function new();
      cfg      = '0;
      armed    = 1'b0;
      t_arm    = '0;
      t_disarm = '0;
      t_door   = '0;
      t_motion = '0;
      t_alarm  = '0;
      failures = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [CODE_W-1:0] v);
      case (idx)
        CFG_DOOR_CODE:     cfg.door_code          = v;
        CFG_MOTION_CODE:   cfg.motion_code        = v;
        CFG_ARM_CODE_A:    cfg.arm_code_a         = v;
        CFG_DISARM_CODE_A: cfg.disarm_code_a      = v;
        CFG_ARM_CODE_B:    cfg.arm_code_b         = v;
        CFG_DISARM_CODE_B: cfg.disarm_code_b      = v;
        CFG_START_DELAY:   cfg.start_delay_ms     = v;
        CFG_REPEAT_INTV:   cfg.repeat_interval_ms = v;
        default: ;
      endcase
    endfunction

    // wrapped time difference
    function logic [TIME_W-1:0] elapsed(logic [TIME_W-1:0] a, logic [TIME_W-1:0] b);
      return a - b;
    endfunction

    // door/motion hit; sensor timestamp moves only when the alarm is raised
    function ev_t sensor_hit(logic [TIME_W-1:0] now, bit is_door);
      logic [TIME_W-1:0] own;
      own = is_door ? t_door : t_motion;
      if (elapsed(now, own) <= HOLDOFF_MS) return EV_HOLDOFF;
      if (!armed) return EV_OFF;
      if (elapsed(now, t_arm) <= cfg.start_delay_ms) return EV_START;
      if (elapsed(now, t_alarm) <= cfg.repeat_interval_ms) return EV_REPEAT;
      t_alarm = now;
      if (is_door) begin
        t_door = now;
        return EV_DOOR;
      end
      t_motion = now;
      return EV_MOTION;
    endfunction

    function void note_poll(in_item_t p);
      logic [TIME_W-1:0] now;
      bit                tone;
      bit                off;
      ev_t               ev;
      out_item_t         r;
      now  = p.now_ms;
      off  = 1'b0;
      ev   = EV_NONE;
      // tone is judged on the state before this poll
      tone = armed && (elapsed(now, t_arm) <= cfg.start_delay_ms);
      if (p.code_valid) begin
        // priority: arm, disarm, door, motion
        if (p.rx_code == cfg.arm_code_a || p.rx_code == cfg.arm_code_b) begin
          if (elapsed(now, t_arm) <= HOLDOFF_MS) begin
            ev = EV_HOLDOFF;
          end else begin
            armed = 1'b1;
            t_arm = now;
            ev    = EV_ARMED;
          end
        end else if (p.rx_code == cfg.disarm_code_a || p.rx_code == cfg.disarm_code_b) begin
          if (elapsed(now, t_disarm) <= HOLDOFF_MS) begin
            ev = EV_HOLDOFF;
          end else begin
            armed    = 1'b0;
            t_disarm = now;
            off      = 1'b1;
            ev       = EV_DISARMED;
          end
        end else if (p.rx_code == cfg.door_code) begin
          ev = sensor_hit(now, 1'b1);
        end else if (p.rx_code == cfg.motion_code) begin
          ev = sensor_hit(now, 1'b0);
        end else begin
          ev = EV_UNKNOWN;
        end
      end
      r.armed        = armed;
      r.alarm        = (ev == EV_DOOR) || (ev == EV_MOTION);
      r.door_alarm   = (ev == EV_DOOR);
      r.motion_alarm = (ev == EV_MOTION);
      r.arming_tone  = tone;
      r.off_tone     = off;
      r.event_res    = ev;
      pending_results.push_back(r);
    endfunction

    function string fmt(out_item_t r);
      return $sformatf("armed=%b alarm=%b door=%b motion=%b tone=%b off=%b ev=%0d",
                       r.armed, r.alarm, r.door_alarm, r.motion_alarm,
                       r.arming_tone, r.off_tone, r.event_res);
    endfunction

    function void note_failure(string msg);
      failures++;
      if (failures <= 10) $display("%0t: %s", $time, msg);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        note_failure({"result beat with no poll outstanding: ", fmt(got)});
        return;
      end
      want = pending_results.pop_front();
      if (got.armed !== want.armed || got.alarm !== want.alarm ||
          got.door_alarm !== want.door_alarm || got.motion_alarm !== want.motion_alarm ||
          got.arming_tone !== want.arming_tone || got.off_tone !== want.off_tone ||
          got.event_res !== want.event_res)
        note_failure({"result mismatch: exp ", fmt(want), " got ", fmt(got)});
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_data;
  logic                 out_valid;
  logic                 out_stall;
  out_item_t            out_data;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CODE_W-1:0]    cfg_wdata;

  alarm_scoreboard sb = new();

  // idle rates in percent of cycles, changed per phase
  int                send_idle_pct;
  int                stall_pct;
  // running poll timestamp for the random part
  logic [TIME_W-1:0] now_cur;

  intrusion_alarm_controller_core uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // receiver back-pressure, re-rolled every cycle
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // beats are taken at the rising edge; the block's registers settle after it
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.note_poll(in_data);
      if (out_valid && !out_stall) sb.check_result(out_data);
    end
  end

  // one poll beat: optional idle gap, then hold until taken
  task automatic send_poll(input logic [TIME_W-1:0] now, input logic valid_code,
                           input logic [CODE_W-1:0] code);
    in_item_t p;
    p.now_ms     = now;
    p.code_valid = valid_code;
    p.rx_code    = code;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = p;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // wait until every owed result is back and the pipe has emptied
  task automatic drain();
    in_valid = 1'b0;
    while (sb.pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CODE_W-1:0] v);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = v;
    sb.set_reg(idx, v);
    @(negedge clk);
  endtask

  // only called with the block idle
  task automatic configure(input logic [CODE_W-1:0] door, input logic [CODE_W-1:0] motion,
                           input logic [CODE_W-1:0] arm_a, input logic [CODE_W-1:0] dis_a,
                           input logic [CODE_W-1:0] arm_b, input logic [CODE_W-1:0] dis_b,
                           input logic [TIME_W-1:0] start, input logic [TIME_W-1:0] rep);
    write_reg(CFG_DOOR_CODE, door);
    write_reg(CFG_MOTION_CODE, motion);
    write_reg(CFG_ARM_CODE_A, arm_a);
    write_reg(CFG_DISARM_CODE_A, dis_a);
    write_reg(CFG_ARM_CODE_B, arm_b);
    write_reg(CFG_DISARM_CODE_B, dis_b);
    write_reg(CFG_START_DELAY, start);
    write_reg(CFG_REPEAT_INTV, rep);
    cfg_we = 1'b0;
  endtask

  // Mostly arm sessions: arm past holdoff, a burst of sensor hits, usually a
  // disarm. The rest is noise: time jumps, idle polls, unknown and stray codes.
  task automatic run_phase(input int n_items);
    int                sent;
    int                k;
    int                r;
    logic [CODE_W-1:0] code;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 70) begin
        now_cur += $urandom_range(2001, 4000);
        send_poll(now_cur, 1'b1, $urandom_range(1) ? sb.cfg.arm_code_a : sb.cfg.arm_code_b);
        k = $urandom_range(3, 8);
        repeat (k) begin
          now_cur += $urandom_range(0, 2500);
          send_poll(now_cur, 1'b1, $urandom_range(1) ? sb.cfg.door_code : sb.cfg.motion_code);
        end
        sent += k + 1;
        if ($urandom_range(3) != 0) begin
          now_cur += $urandom_range(0, 3000);
          send_poll(now_cur, 1'b1,
                    $urandom_range(1) ? sb.cfg.disarm_code_a : sb.cfg.disarm_code_b);
          sent++;
        end
      end else begin
        if ($urandom_range(99) < 15) now_cur = $urandom;
        else now_cur += $urandom_range(0, 3000);
        r = $urandom_range(7);
        case (r)
          0: code = sb.cfg.arm_code_a;
          1: code = sb.cfg.arm_code_b;
          2: code = sb.cfg.disarm_code_a;
          3: code = sb.cfg.disarm_code_b;
          4: code = sb.cfg.door_code;
          5: code = sb.cfg.motion_code;
          default: code = $urandom;
        endcase
        // a fifth of the noise carries no code at all
        send_poll(now_cur, ($urandom_range(4) != 0), code);
        sent++;
      end
    end
  endtask

  initial begin
    #4_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    logic [CODE_W-1:0] y;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    out_stall     = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_wdata     = '0;
    send_idle_pct = 8;
    stall_pct     = 52;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // all registers at reset: code 0 matches everything, arm wins;
    // timestamps start at 0 so early commands fall in holdoff
    send_poll(32'd0, 1'b0, 32'd0);
    send_poll(32'd100, 1'b1, 32'd0);
    send_poll(32'd2000, 1'b1, 32'd0);
    send_poll(32'd2001, 1'b1, 32'd0);
    drain();

    configure(32'hFFFF_FFFF, 32'h1234_5678, 32'hA5A5_0001, 32'h5A5A_0002,
              32'h0000_0003, 32'h8000_0004, 32'd1000, 32'd3000);
    send_poll(32'd1500, 1'b1, 32'hFFFF_FFFF);       // sensor holdoff after reset
    send_poll(32'd2500, 1'b1, 32'hFFFF_FFFF);       // exit delay
    send_poll(32'd3001, 1'b1, 32'hFFFF_FFFF);       // exit delay, on the limit
    send_poll(32'd3002, 1'b1, 32'hFFFF_FFFF);       // door alarm
    send_poll(32'd4000, 1'b1, 32'h1234_5678);       // repeat interval
    send_poll(32'd4500, 1'b1, 32'hFFFF_FFFF);       // door's own holdoff
    send_poll(32'd6003, 1'b1, 32'h1234_5678);       // motion alarm
    send_poll(32'd6100, 1'b1, 32'h0BAD_C0DE);       // unknown code
    send_poll(32'd6200, 1'b0, 32'hFFFF_FFFF);       // no code
    send_poll(32'd6300, 1'b1, 32'h0000_0003);       // arm while armed
    send_poll(32'd6400, 1'b1, 32'h5A5A_0002);       // disarm
    send_poll(32'd6500, 1'b1, 32'h8000_0004);       // disarm holdoff
    send_poll(32'd8401, 1'b1, 32'h5A5A_0002);       // disarm while disarmed
    send_poll(32'd8500, 1'b1, 32'hFFFF_FFFF);       // sensor while disarmed
    send_poll(32'hFFFF_FF00, 1'b1, 32'hA5A5_0001);  // arm near wrap
    send_poll(32'hFFFF_FFFF, 1'b0, 32'hFFFF_FFFF);  // max fields, no code
    send_poll(32'h0000_0010, 1'b1, 32'hFFFF_FFFF);  // exit delay across wrap
    send_poll(32'd5016, 1'b1, 32'h1234_5678);       // motion alarm across wrap
    drain();
    now_cur = 32'd5016;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph / 2)
        0: begin
          send_idle_pct = 8;
          stall_pct     = 52;
        end
        1: begin
          send_idle_pct = 52;
          stall_pct     = 8;
        end
        default: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
      endcase
      case (ph)
        0: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     32'd0, 32'd0);
        1: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     32'hFFFF_FFFF, 32'hFFFF_FFFF);
        2: configure(32'h0000_0000, 32'hFFFF_FFFF, $urandom, $urandom, $urandom, $urandom,
                     $urandom_range(3000), $urandom_range(5000));
        3: begin
          // motion shadowed by disarm A, disarm B shadowed by arm A
          y = $urandom;
          configure($urandom, y, 32'h7777_0001, y, $urandom, 32'h7777_0001,
                    $urandom_range(3000), $urandom_range(5000));
        end
        default: configure($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                           $urandom_range(3000), $urandom_range(5000));
      endcase
      run_phase(200);
      drain();
    end

    drain();
    if (sb.failures == 0 && sb.pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
